// ----- design/koc_pkg.sv -----
package koc_pkg;

    // Field widths fixed by the item formats
    localparam int MODE_W = 2;
    localparam int CHAR_W = 8;
    localparam int LEN_W  = 4;
    localparam int CODE_W = 16;
    localparam int OCC_W  = 32;

    // Default sizing of the unit
    localparam int MAX_MOTIF_DEF  = 8;
    localparam int COUNT_BITS_DEF = 32;

    // Reset value of the longest-length register
    localparam logic [LEN_W-1:0] CFG_MAX_LEN_RST = 4'd8;

    // Item modes
    localparam logic [MODE_W-1:0] MODE_ADD   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

    // Base characters
    localparam logic [CHAR_W-1:0] CHAR_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_C = 8'h43;
    localparam logic [CHAR_W-1:0] CHAR_G = 8'h47;
    localparam logic [CHAR_W-1:0] CHAR_T = 8'h54;

    // Base codes
    localparam logic [1:0] BASE_A = 2'd0;
    localparam logic [1:0] BASE_C = 2'd1;
    localparam logic [1:0] BASE_G = 2'd2;
    localparam logic [1:0] BASE_T = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [CHAR_W-1:0] base_char;
        logic [LEN_W-1:0]  query_length;
        logic [CODE_W-1:0] query_kmer;
    } t_in_item;

    typedef struct packed {
        logic [LEN_W-1:0]  kmer_length;
        logic [CODE_W-1:0] kmer_code;
        logic [OCC_W-1:0]  occurrence_count;
        logic              last;
    } t_out_item;

    // One result slot of the cell chain
    typedef struct packed {
        logic      vld;
        t_out_item item;
    } t_res_slot;

    // Control broadcast from the sequencer to every cell
    typedef struct packed {
        logic             win_shift;
        logic [1:0]       base;
        logic             clr;
        logic             rd_query;
        logic             upd;
        logic             qry;
        logic             res_shift;
        logic [LEN_W-1:0] lim;
        logic [LEN_W-1:0] qlen;
    } t_cell_ctrl;

    typedef struct packed {
        logic       ok;
        logic [1:0] code;
    } t_base_dec;

    // Map an ASCII character to a 2-bit base code
    function automatic t_base_dec base_decode(input logic [CHAR_W-1:0] ch);
        t_base_dec d;
        d.ok   = 1'b1;
        d.code = BASE_A;
        unique case (ch)
            CHAR_A: d.code = BASE_A;
            CHAR_C: d.code = BASE_C;
            CHAR_G: d.code = BASE_G;
            CHAR_T: d.code = BASE_T;
            default: d.ok = 1'b0;
        endcase
        return d;
    endfunction

endpackage

// ----- design/koc_ram.sv -----
module koc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/koc_cell.sv -----
module koc_cell #(
    parameter int K          = 1,
    parameter int MAX_MOTIF  = koc_pkg::MAX_MOTIF_DEF,
    parameter int COUNT_BITS = koc_pkg::COUNT_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  koc_pkg::t_cell_ctrl    i_ctrl,
    input  logic [2*MAX_MOTIF-1:0] i_clr_addr,
    input  logic [2*MAX_MOTIF-1:0] i_qcode,
    input  logic [2*MAX_MOTIF-1:0] i_code,
    output logic [2*MAX_MOTIF-1:0] o_code,
    input  koc_pkg::t_res_slot     i_res,
    output koc_pkg::t_res_slot     o_res
);

    localparam int WIN_W  = 2 * MAX_MOTIF;
    localparam int AW     = 2 * K;
    localparam int DEPTH  = 1 << AW;
    localparam int LEN_W  = koc_pkg::LEN_W;
    localparam int CODE_W = koc_pkg::CODE_W;
    localparam int OCC_W  = koc_pkg::OCC_W;

    logic [AW-1:0]         r_code;
    logic [WIN_W-1:0]      n_code_full;
    logic [AW-1:0]         rd_addr;
    logic [AW-1:0]         wr_addr;
    logic [COUNT_BITS-1:0] rdata;
    logic [COUNT_BITS-1:0] inc;
    logic [COUNT_BITS-1:0] wdata;
    logic                  we;
    logic                  in_range;
    koc_pkg::t_res_slot    r_res;

    // Take the neighbor's shorter k-mer and append the new base
    assign n_code_full = (i_code << 2) | WIN_W'(i_ctrl.base);
    assign o_code      = WIN_W'(r_code);

    assign in_range = (i_ctrl.lim >= LEN_W'(K));
    assign rd_addr  = i_ctrl.rd_query ? i_qcode[AW-1:0] : r_code;

    // Saturating increment of the stored count
    assign inc = (&rdata) ? rdata : rdata + COUNT_BITS'(1);

    // Clear sweep or count update
    assign we      = i_ctrl.clr | (i_ctrl.upd & in_range);
    assign wr_addr = i_ctrl.clr ? i_clr_addr[AW-1:0] : r_code;
    assign wdata   = i_ctrl.clr ? '0 : inc;

    koc_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (wr_addr),
        .i_wdata (wdata),
        .i_raddr (rd_addr),
        .o_rdata (rdata)
    );

    // Hold the k-mer of this length and the result slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code    <= '0;
            r_res.vld <= 1'b0;
        end else begin
            if (i_ctrl.win_shift) begin
                r_code <= n_code_full[AW-1:0];
            end
            if (i_ctrl.upd) begin
                r_res.vld                   <= in_range;
                r_res.item.kmer_length      <= LEN_W'(K);
                r_res.item.kmer_code        <= CODE_W'(r_code);
                r_res.item.occurrence_count <= OCC_W'(inc);
                r_res.item.last             <= (i_ctrl.lim == LEN_W'(K));
            end else if (i_ctrl.qry) begin
                r_res.vld                   <= (i_ctrl.qlen == LEN_W'(K));
                r_res.item.kmer_length      <= LEN_W'(K);
                r_res.item.kmer_code        <= CODE_W'(rd_addr);
                r_res.item.occurrence_count <= OCC_W'(rdata);
                r_res.item.last             <= 1'b1;
            end else if (i_ctrl.res_shift) begin
                r_res <= i_res;
            end
        end
    end

    assign o_res = r_res;

endmodule

// ----- design/kmer_occurrence_counter_unit.sv -----
// K-mer occurrence counter. Characters enter one per item; each A/C/G/T
// extends the current run and bumps one saturating counter per length
// 1..min(run, configured longest length), reporting every new count shortest
// first; any other character ends the run. A row of MAX_MOTIF cells holds the
// window (cell k keeps the newest k-mer of length k) and owns a 4^k-entry count
// RAM. An add item runs accept, RAM read, write-back, load of the output
// register, then one result per cycle out of the cell chain unless the output
// stalls; a read with a valid length runs accept, RAM read and capture, then its
// result walks down the chain to the output register, and a read with a bad
// length loads an empty final result directly. Clear items and reset both run a
// sweep over 4^MAX_MOTIF RAM rows (65536 at the default size), during which no
// item is accepted; the clear acknowledgement follows the sweep.
module kmer_occurrence_counter_unit #(
    parameter int MAX_MOTIF  = koc_pkg::MAX_MOTIF_DEF,
    parameter int COUNT_BITS = koc_pkg::COUNT_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [koc_pkg::LEN_W-1:0]   i_cfg_wdata,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  koc_pkg::t_in_item           i_in_item,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output koc_pkg::t_out_item          o_out_item
);

    localparam int WIN_W = 2 * MAX_MOTIF;
    localparam int LEN_W = koc_pkg::LEN_W;
    localparam int RUN_W = $clog2(MAX_MOTIF + 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_WRITE,
        ST_DRAIN
    } t_state;

    t_state             r_state, n_state;
    logic [LEN_W-1:0]   r_max_len, n_max_len;
    logic [RUN_W-1:0]   r_run, n_run;
    logic [LEN_W-1:0]   r_lim, n_lim;
    logic [LEN_W-1:0]   r_qlen, n_qlen;
    logic [WIN_W-1:0]   r_qcode, n_qcode;
    logic               r_is_read, n_is_read;
    logic [WIN_W-1:0]   r_clr_addr, n_clr_addr;
    logic               r_clr_ack, n_clr_ack;
    koc_pkg::t_out_item r_out, n_out;
    logic               r_out_vld, n_out_vld;

    koc_pkg::t_cell_ctrl cell_ctrl;
    koc_pkg::t_base_dec  dec;
    koc_pkg::t_res_slot  res_bus  [MAX_MOTIF+1];
    logic [WIN_W-1:0]    code_bus [MAX_MOTIF+1];

    logic             accept;
    logic             out_take;
    logic             load;
    logic [RUN_W-1:0] run_inc;
    logic [LEN_W-1:0] cap;
    logic [LEN_W-1:0] run_ext;
    logic             bad_qlen;

    assign accept   = i_in_valid & (r_state == ST_IDLE);
    assign out_take = r_out_vld & ~i_out_stall;
    assign dec      = koc_pkg::base_decode(i_in_item.base_char);

    // Count length limit for the run after this base
    assign run_inc  = (r_run < RUN_W'(MAX_MOTIF)) ? r_run + RUN_W'(1) : r_run;
    assign run_ext  = LEN_W'(run_inc);
    assign cap      = (r_max_len > LEN_W'(MAX_MOTIF)) ? LEN_W'(MAX_MOTIF) : r_max_len;
    assign bad_qlen = (i_in_item.query_length == '0)
                    | (i_in_item.query_length > LEN_W'(MAX_MOTIF));

    // Move the front result of the chain into the output register
    assign load = (r_state == ST_DRAIN) & res_bus[0].vld & (~r_out_vld | out_take);

    // Broadcast control to the cells
    always_comb begin
        cell_ctrl           = '0;
        cell_ctrl.win_shift = accept & (i_in_item.mode == koc_pkg::MODE_ADD) & dec.ok;
        cell_ctrl.base      = dec.code;
        cell_ctrl.clr       = (r_state == ST_CLEAR);
        cell_ctrl.rd_query  = r_is_read;
        cell_ctrl.upd       = (r_state == ST_WRITE) & ~r_is_read;
        cell_ctrl.qry       = (r_state == ST_WRITE) & r_is_read;
        cell_ctrl.res_shift = (r_state == ST_DRAIN) & (~res_bus[0].vld | load);
        cell_ctrl.lim       = r_lim;
        cell_ctrl.qlen      = r_qlen;
    end

    // Sequencer next state
    always_comb begin
        n_state    = r_state;
        n_max_len  = r_max_len;
        n_run      = r_run;
        n_lim      = r_lim;
        n_qlen     = r_qlen;
        n_qcode    = r_qcode;
        n_is_read  = r_is_read;
        n_clr_addr = r_clr_addr;
        n_clr_ack  = r_clr_ack;
        n_out      = r_out;
        n_out_vld  = r_out_vld;

        if (i_cfg_we) begin
            n_max_len = i_cfg_wdata;
        end

        unique case (r_state)
            ST_CLEAR: begin
                n_clr_addr = r_clr_addr + WIN_W'(1);
                if (&r_clr_addr) begin
                    n_clr_ack = 1'b0;
                    if (r_clr_ack) begin
                        n_out     = '0;
                        n_out.last = 1'b1;
                        n_out_vld = 1'b1;
                        n_state   = ST_DRAIN;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    unique case (i_in_item.mode)
                        koc_pkg::MODE_ADD: begin
                            if (dec.ok) begin
                                n_run     = run_inc;
                                n_lim     = (cap > run_ext) ? run_ext : cap;
                                n_is_read = 1'b0;
                                if (n_lim != '0) begin
                                    n_state = ST_READ;
                                end
                            end else begin
                                n_run = '0;
                            end
                        end
                        koc_pkg::MODE_CLEAR: begin
                            n_clr_addr = '0;
                            n_clr_ack  = 1'b1;
                            n_state    = ST_CLEAR;
                        end
                        koc_pkg::MODE_READ: begin
                            if (bad_qlen) begin
                                n_out             = '0;
                                n_out.kmer_length = i_in_item.query_length;
                                n_out.last        = 1'b1;
                                n_out_vld         = 1'b1;
                                n_state           = ST_DRAIN;
                            end else begin
                                n_qlen    = i_in_item.query_length;
                                n_qcode   = WIN_W'(i_in_item.query_kmer);
                                n_is_read = 1'b1;
                                n_state   = ST_READ;
                            end
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_READ: begin
                n_state = ST_WRITE;
            end
            ST_WRITE: begin
                n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (out_take) begin
                    n_out_vld = 1'b0;
                    if (r_out.last) begin
                        n_is_read = 1'b0;
                        n_state   = ST_IDLE;
                    end
                end
                if (load) begin
                    n_out     = res_bus[0].item;
                    n_out_vld = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_max_len  <= koc_pkg::CFG_MAX_LEN_RST;
            r_run      <= '0;
            r_is_read  <= 1'b0;
            r_clr_addr <= '0;
            r_clr_ack  <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_max_len  <= n_max_len;
            r_run      <= n_run;
            r_lim      <= n_lim;
            r_qlen     <= n_qlen;
            r_qcode    <= n_qcode;
            r_is_read  <= n_is_read;
            r_clr_addr <= n_clr_addr;
            r_clr_ack  <= n_clr_ack;
            r_out      <= n_out;
            r_out_vld  <= n_out_vld;
        end
    end

    // Chain ends: no shorter k-mer before the first cell, no result after the last
    assign code_bus[0]         = '0;
    assign res_bus[MAX_MOTIF]  = '0;

    for (genvar g = 0; g < MAX_MOTIF; g++) begin : g_cell
        koc_cell #(
            .K          (g + 1),
            .MAX_MOTIF  (MAX_MOTIF),
            .COUNT_BITS (COUNT_BITS)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (cell_ctrl),
            .i_clr_addr (r_clr_addr),
            .i_qcode    (r_qcode),
            .i_code     (code_bus[g]),
            .o_code     (code_bus[g+1]),
            .i_res      (res_bus[g+1]),
            .o_res      (res_bus[g])
        );
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

endmodule

// ----- design/koc_checker.sv -----
module koc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input koc_pkg::t_out_item o_out_item
);

    // Reset starts the clearing sweep with nothing on the output
    a_reset_sweep: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_stall)
        else $error("output valid or input open right after reset");

    // Hold off new items while a result is pending
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input open while a result is pending");

    // Follow a non-final result with the next length at once
    a_next_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_out_item.last |=>
            o_out_valid && (o_out_item.kmer_length == $past(o_out_item.kmer_length) + 4'd1))
        else $error("results of one item not contiguous or out of length order");

    // Zero-length results are final, empty acknowledgements
    a_zero_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.kmer_length == 4'd0) |->
            o_out_item.last && (o_out_item.kmer_code == 16'd0)
            && (o_out_item.occurrence_count == 32'd0))
        else $error("zero-length result not an empty final item");

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled output item changed");

endmodule

bind kmer_occurrence_counter_unit koc_checker u_koc_checker (.*);

// ----- test/testbench.sv -----
// Tracks the k-mer counts of the block and holds the results it still owes.
class kmer_count_scoreboard;
    koc_pkg::t_out_item pending_counts[$];
    int unsigned count_table[((4 << (2 * koc_pkg::MAX_MOTIF_DEF)) - 4) / 3];
    logic [15:0] window;
    int          run_len;
    logic [3:0]  max_len;
    int          mismatches;
    int          results_checked;

    function new();
        window          = '0;
        run_len         = 0;
        max_len         = koc_pkg::CFG_MAX_LEN_RST;
        mismatches      = 0;
        results_checked = 0;
        foreach (count_table[i]) count_table[i] = 0;
    endfunction

    function void set_max_len(logic [3:0] v);
        max_len = v;
    endfunction

    function logic [15:0] kmer_mask(int k);
        int unsigned m;
        m = (32'd1 << (2 * k)) - 1;
        return m[15:0];
    endfunction

    // First table row of the block that holds the k-mers of length k
    function int block_base(int k);
        return ((1 << (2 * k)) - 4) / 3;
    endfunction

    function void push_count(int k, logic [15:0] code, int unsigned cnt, bit fin);
        koc_pkg::t_out_item r;
        r.kmer_length      = 4'(k);
        r.kmer_code        = code;
        r.occurrence_count = cnt;
        r.last             = fin;
        pending_counts.push_back(r);
    endfunction

    // Advance the window and counts for one accepted item
    function void note_item(koc_pkg::t_in_item it);
        logic [1:0]  b;
        bit          is_base;
        int          lim;
        int          idx;
        logic [15:0] code;
        case (it.mode)
            koc_pkg::MODE_ADD: begin
                is_base = 1'b1;
                b       = koc_pkg::BASE_A;
                case (it.base_char)
                    koc_pkg::CHAR_A: b = koc_pkg::BASE_A;
                    koc_pkg::CHAR_C: b = koc_pkg::BASE_C;
                    koc_pkg::CHAR_G: b = koc_pkg::BASE_G;
                    koc_pkg::CHAR_T: b = koc_pkg::BASE_T;
                    default: is_base = 1'b0;
                endcase
                if (!is_base) begin
                    // any other character ends the run, window stays
                    run_len = 0;
                end else begin
                    window = {window[13:0], b};
                    if (run_len < koc_pkg::MAX_MOTIF_DEF) run_len++;
                    lim = (max_len > koc_pkg::MAX_MOTIF_DEF) ? koc_pkg::MAX_MOTIF_DEF
                                                             : int'(max_len);
                    if (lim > run_len) lim = run_len;
                    for (int k = 1; k <= lim; k++) begin
                        code = window & kmer_mask(k);
                        idx  = block_base(k) + int'(code);
                        if (count_table[idx] != 32'hFFFF_FFFF) count_table[idx]++;
                        push_count(k, code, count_table[idx], k == lim);
                    end
                end
            end
            koc_pkg::MODE_CLEAR: begin
                foreach (count_table[i]) count_table[i] = 0;
                push_count(0, '0, 0, 1'b1);
            end
            koc_pkg::MODE_READ: begin
                if (it.query_length == 0 || it.query_length > koc_pkg::MAX_MOTIF_DEF) begin
                    push_count(it.query_length, '0, 0, 1'b1);
                end else begin
                    code = it.query_kmer & kmer_mask(it.query_length);
                    idx  = block_base(it.query_length) + int'(code);
                    push_count(it.query_length, code, count_table[idx], 1'b1);
                end
            end
            default: begin
                // undefined mode: no effect
            end
        endcase
    endfunction

    // Compare one result against the oldest expected count
    function void check_result(koc_pkg::t_out_item got);
        koc_pkg::t_out_item want;
        if (pending_counts.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: unexpected result len=%0d code=%h count=%0d last=%0b",
                         $time, got.kmer_length, got.kmer_code,
                         got.occurrence_count, got.last);
            return;
        end
        want = pending_counts.pop_front();
        results_checked++;
        if (got.kmer_length !== want.kmer_length || got.kmer_code !== want.kmer_code ||
            got.occurrence_count !== want.occurrence_count || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
                $display({"%0t: mismatch exp len=%0d code=%h count=%0d last=%0b,",
                          " got len=%0d code=%h count=%0d last=%0b"},
                         $time, want.kmer_length, want.kmer_code, want.occurrence_count,
                         want.last, got.kmer_length, got.kmer_code,
                         got.occurrence_count, got.last);
        end
    endfunction
endclass

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [koc_pkg::MODE_W-1:0] MODE_NONE = 2'd3;
    localparam int IDLE_LIMIT    = 200_000;
    localparam int SETTLE_CYCLES = 24;
    localparam int SEG_ITEMS     = 22;
    localparam int NUM_SEGS      = 6;
    localparam int HOLD_CYCLES   = 300;

    logic                      i_clk       = 1'b0;
    logic                      i_rst_n     = 1'b0;
    logic                      i_cfg_we    = 1'b0;
    logic [koc_pkg::LEN_W-1:0] i_cfg_wdata = '0;
    logic                      i_in_valid  = 1'b0;
    logic                      o_in_stall;
    koc_pkg::t_in_item         i_in_item   = '0;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    koc_pkg::t_out_item        o_out_item;

    kmer_count_scoreboard sb;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    bit hold_request  = 1'b0;
    int hold_left     = 0;
    int idle_cycles   = 0;
    int n_adds        = 0;
    int n_reads       = 0;
    int n_clears      = 0;
    int n_ignored     = 0;

    kmer_occurrence_counter_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always #10 i_clk = ~i_clk;

    // Drive the result stall: long hold-off on request, random otherwise
    always @(posedge i_clk) begin
        if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Check every accepted result
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            sb.check_result(o_out_item);
        end
    end

    // Stop the run when no item moves for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_stall === 1'b0) || (o_out_valid === 1'b1 && !i_out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no handshake for %0d cycles", IDLE_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    function automatic koc_pkg::t_in_item mk_item(logic [1:0] mode, logic [7:0] ch,
                                                  logic [3:0] qlen, logic [15:0] qkmer);
        koc_pkg::t_in_item it;
        it.mode         = mode;
        it.base_char    = ch;
        it.query_length = qlen;
        it.query_kmer   = qkmer;
        return it;
    endfunction

    function automatic logic [7:0] base_char_of(int sel);
        case (sel)
            0: return koc_pkg::CHAR_A;
            1: return koc_pkg::CHAR_C;
            2: return koc_pkg::CHAR_G;
            default: return koc_pkg::CHAR_T;
        endcase
    endfunction

    // Mostly bases, some other characters, reads of recent and random k-mers, some undefined modes
    function automatic koc_pkg::t_in_item random_item();
        koc_pkg::t_in_item it;
        int                pick;
        int                qlen;
        logic [15:0]       m;
        pick = $urandom_range(0, 99);
        it   = mk_item(koc_pkg::MODE_ADD, 8'($urandom), 4'($urandom), 16'($urandom));
        if (pick < 66) begin
            it.base_char = base_char_of($urandom_range(0, 3));
        end else if (pick < 74) begin
            // keep the random character
        end else if (pick < 92) begin
            it.mode = koc_pkg::MODE_READ;
            pick    = $urandom_range(0, 9);
            if (pick < 6) begin
                // a k-mer that just went by, upper bits as noise
                qlen = $urandom_range(1, koc_pkg::MAX_MOTIF_DEF);
                m    = sb.kmer_mask(qlen);
                it.query_length = 4'(qlen);
                it.query_kmer   = (16'($urandom) & ~m) | (sb.window & m);
            end else if (pick < 8) begin
                it.query_length = 4'($urandom_range(1, koc_pkg::MAX_MOTIF_DEF));
            end
        end else begin
            it.mode = MODE_NONE;
        end
        return it;
    endfunction

    // Offer one item, with random idle cycles ahead of it
    task automatic send_item(input koc_pkg::t_in_item it);
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        sb.note_item(it);
        case (it.mode)
            koc_pkg::MODE_ADD:   n_adds++;
            koc_pkg::MODE_READ:  n_reads++;
            koc_pkg::MODE_CLEAR: n_clears++;
            default:             n_ignored++;
        endcase
    endtask

    // Hold the input until all owed results are in, then let the pipe settle
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (sb.pending_counts.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_max_len(input logic [3:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_max_len(v);
    endtask

    initial begin
        koc_pkg::t_in_item it;
        int                useful;
        logic [3:0]        cfg_val;
        sb = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty read, a run that saturates, breaks, bad lengths, clear
        send_item(mk_item(koc_pkg::MODE_READ, 8'($urandom), 4'd1, 16'h0000));
        for (int i = 0; i < 9; i++)
            send_item(mk_item(koc_pkg::MODE_ADD, base_char_of(i % 4), 4'($urandom),
                              16'($urandom)));
        send_item(mk_item(koc_pkg::MODE_ADD, 8'h61, 4'($urandom), 16'($urandom)));
        send_item(mk_item(koc_pkg::MODE_ADD, koc_pkg::CHAR_G, 4'($urandom), 16'($urandom)));
        send_item(mk_item(koc_pkg::MODE_READ, 8'($urandom), 4'd8, sb.window));
        send_item(mk_item(koc_pkg::MODE_READ, 8'($urandom), 4'd2, 16'hFFFF));
        send_item(mk_item(koc_pkg::MODE_READ, 8'($urandom), 4'd0, 16'($urandom)));
        send_item(mk_item(koc_pkg::MODE_READ, 8'($urandom), 4'd15, 16'($urandom)));
        send_item(mk_item(koc_pkg::MODE_READ, 8'($urandom), 4'd9, 16'($urandom)));
        send_item(mk_item(MODE_NONE, 8'($urandom), 4'($urandom), 16'($urandom)));
        send_item(mk_item(koc_pkg::MODE_CLEAR, 8'($urandom), 4'($urandom), 16'($urandom)));
        send_item(mk_item(koc_pkg::MODE_READ, 8'($urandom), 4'd1, {14'h0, koc_pkg::BASE_G}));
        send_item(mk_item(koc_pkg::MODE_ADD, koc_pkg::CHAR_T, 4'($urandom), 16'($urandom)));
        send_item(mk_item(koc_pkg::MODE_ADD, 8'hFF, 4'($urandom), 16'($urandom)));
        send_item(mk_item(koc_pkg::MODE_ADD, 8'h00, 4'($urandom), 16'($urandom)));
        send_item(mk_item(koc_pkg::MODE_ADD, koc_pkg::CHAR_C, 4'($urandom), 16'($urandom)));
        drain_results();

        // Random segments, each with its own max length and one of four idle and stall patterns
        cfg_val = '0;
        for (int seg = 0; seg < NUM_SEGS; seg++) begin
            case (seg)
                0: cfg_val = 4'd15;
                1: cfg_val = 4'd1;
                2: cfg_val = 4'd0;
                3: cfg_val = 4'd5;
                4: cfg_val = 4'd8;
                default: cfg_val = 4'($urandom_range(2, 7));
            endcase
            write_max_len(cfg_val);
            case (seg % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 68; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 68; end
                default: begin send_idle_pct = 15; stall_pct = 15; end
            endcase
            // back up the result side while items keep coming
            if (seg == 0 || seg == 4) hold_request = 1'b1;
            useful = 0;
            while (useful < SEG_ITEMS) begin
                if (seg % 3 == 2 && useful == SEG_ITEMS / 2)
                    it = mk_item(koc_pkg::MODE_CLEAR, 8'($urandom), 4'($urandom),
                                 16'($urandom));
                else
                    it = random_item();
                send_item(it);
                if (it.mode != MODE_NONE) useful++;
            end
            drain_results();
        end

        $display("Covered %0d adds, %0d reads, %0d clears, %0d ignored items; %0d checked",
                 n_adds, n_reads, n_clears, n_ignored, sb.results_checked);
        $display("Max lengths 8, 15, 1, 0, 5, 8, %0d under four idle and stall patterns",
                 cfg_val);
        if (sb.mismatches == 0 && sb.pending_counts.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
